FILE: rtl/core/gsa_pkg.sv
package gsa_pkg;

    localparam logic [1:0] FUNC_ALLOC  = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_CHECK  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_STALE = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    // Free queue control: clear writes the init pattern, pop/push are pre-qualified.
    typedef struct packed {
        logic clear;
        logic pop;
        logic push;
    } t_q_req;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_flags;

endpackage

FILE: rtl/core/generational_slot_allocator.sv
// Generational slot allocator: hands out (slot, generation) handles from a pool of SLOTS
// slots kept in a FIFO free queue. One request per cycle is sustained while no stall holds
// the pipeline; o_valid rises after the free-queue read at the accepting edge, then the
// generation-table read, then the output register, since an allocate needs the two memory
// reads in sequence. After reset the block runs a clearing pass that loads the free queue
// with slots 0 to SLOTS-1 and zeroes every generation; o_stall stays high while it runs.
module generational_slot_allocator import gsa_pkg::*; #(
    parameter int SLOTS = 256,
    parameter int GEN_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_slot_index,
    input  logic [15:0] i_handle_generation,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_result_index,
    output logic [15:0] o_result_generation,
    output logic [1:0]  o_status
);

    localparam int SW = $clog2(SLOTS);
    localparam int GW = GEN_BITS;

    typedef logic [SW-1:0] t_wrap_tab [256];

    function automatic t_wrap_tab build_wrap_tab();
        t_wrap_tab tab;
        for (int i = 0; i < 256; i++) begin
            tab[i] = SW'(i % SLOTS);
        end
        return tab;
    endfunction

    localparam t_wrap_tab WRAP_TAB = build_wrap_tab();

    // clearing pass
    logic          r_clearing;
    logic [SW-1:0] r_clr_idx;

    // stage 1: queue read in flight
    logic          r_s1_valid;
    logic [1:0]    r_s1_func;
    logic [SW-1:0] r_s1_slot;
    logic [GW-1:0] r_s1_hgen;
    logic          r_s1_flag;

    // stage 2: generation read in flight
    logic          r_s2_valid;
    logic [1:0]    r_s2_func;
    logic [SW-1:0] r_s2_slot;
    logic [GW-1:0] r_s2_hgen;
    logic          r_s2_flag;

    // output register
    logic          r_o_valid;
    logic [7:0]    r_o_index;
    logic [15:0]   r_o_gen;
    logic [1:0]    r_o_status;

    logic          accept;
    logic          out_free;
    logic          s2_adv;
    logic          s1_adv;
    logic [SW-1:0] in_slot;
    logic          in_alloc;
    logic          in_remove;
    t_q_req        q_req;
    t_q_flags      q_flags;
    logic [SW-1:0] head_slot;
    logic [SW-1:0] s1_slot_eff;
    logic [GW-1:0] gen_rd;
    logic [GW-1:0] gen_inc;
    logic          s2_wr;
    logic [SW-1:0] n_o_slot;
    logic [GW-1:0] n_o_gen;
    logic [1:0]    n_o_status;

    assign out_free = !r_o_valid || !i_stall;
    assign s2_adv   = r_s2_valid && out_free;
    assign s1_adv   = r_s1_valid && (!r_s2_valid || s2_adv);
    assign o_stall  = r_clearing || (r_s1_valid && !s1_adv);
    assign accept   = i_valid && !o_stall;

    assign in_slot   = WRAP_TAB[i_slot_index];
    assign in_alloc  = (i_func == FUNC_ALLOC);
    assign in_remove = (i_func == FUNC_REMOVE);

    assign q_req.clear = r_clearing;
    assign q_req.pop   = accept && in_alloc && !q_flags.empty;
    assign q_req.push  = accept && in_remove && !q_flags.full;

    gsa_free_queue #(
        .SLOTS (SLOTS)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (q_req),
        .i_push_slot (in_slot),
        .i_clr_idx   (r_clr_idx),
        .o_flags     (q_flags),
        .o_head_slot (head_slot)
    );

    assign s1_slot_eff = (r_s1_func == FUNC_ALLOC) ? head_slot : r_s1_slot;

    assign gen_inc = gen_rd + 1'b1;
    assign s2_wr   = s2_adv && (r_s2_func == FUNC_REMOVE) && !r_s2_flag;

    gsa_gen_table #(
        .SLOTS (SLOTS),
        .GW    (GW)
    ) u_gen (
        .i_clk     (i_clk),
        .i_clr     (r_clearing),
        .i_clr_idx (r_clr_idx),
        .i_rd_en   (s1_adv),
        .i_rd_addr (s1_slot_eff),
        .i_wr_en   (s2_wr),
        .i_wr_addr (r_s2_slot),
        .i_wr_data (gen_inc),
        .o_rd_data (gen_rd)
    );

    always_comb begin
        n_o_slot   = r_s2_slot;
        n_o_gen    = gen_rd;
        n_o_status = ST_OK;
        case (r_s2_func)
            FUNC_ALLOC: begin
                if (r_s2_flag) begin
                    n_o_slot   = '0;
                    n_o_gen    = '0;
                    n_o_status = ST_EMPTY;
                end
            end
            FUNC_REMOVE: begin
                if (r_s2_flag) begin
                    n_o_status = ST_FULL;
                end else begin
                    n_o_gen = gen_inc;
                end
            end
            default: begin
                if (gen_rd != r_s2_hgen) begin
                    n_o_status = ST_STALE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_idx <= r_clr_idx + 1'b1;
                if (r_clr_idx == SW'(SLOTS - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_s2_valid <= 1'b1;
            end else if (s2_adv) begin
                r_s2_valid <= 1'b0;
            end
            if (s2_adv) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_func <= i_func;
            r_s1_slot <= in_slot;
            r_s1_hgen <= GW'(i_handle_generation);
            r_s1_flag <= in_alloc ? q_flags.empty : q_flags.full;
        end
        if (s1_adv) begin
            r_s2_func <= r_s1_func;
            r_s2_slot <= s1_slot_eff;
            r_s2_hgen <= r_s1_hgen;
            r_s2_flag <= r_s1_flag;
        end
        if (s2_adv) begin
            r_o_index  <= 8'(n_o_slot);
            r_o_gen    <= 16'(n_o_gen);
            r_o_status <= n_o_status;
        end
    end

    assign o_valid             = r_o_valid;
    assign o_result_index      = r_o_index;
    assign o_result_generation = r_o_gen;
    assign o_status            = r_o_status;

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && (r_o_status == ST_EMPTY)) |-> (r_o_index == '0 && r_o_gen == '0))
        else $error("empty allocate result carries nonzero handle");

    a_clear_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clearing) |-> ($past(r_clr_idx) == SW'(SLOTS - 1)))
        else $error("clearing pass ended early");

    a_remove_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_wr |=> (r_o_valid && (r_o_status == ST_OK)))
        else $error("generation write without ok remove result");

endmodule

FILE: rtl/core/gsa_free_queue.sv
module gsa_free_queue import gsa_pkg::*; #(
    parameter int SLOTS = 256,
    localparam int SW = $clog2(SLOTS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_q_req        i_req,
    input  logic [SW-1:0] i_push_slot,
    input  logic [SW-1:0] i_clr_idx,
    output t_q_flags      o_flags,
    output logic [SW-1:0] o_head_slot
);

    localparam int CW = $clog2(SLOTS + 1);

    logic [SW-1:0] r_mem [SLOTS];
    logic [SW-1:0] r_rd;
    logic [SW-1:0] r_head;
    logic [SW-1:0] r_tail;
    logic [CW-1:0] r_count;
    logic [SW-1:0] n_head;
    logic [SW-1:0] n_tail;
    logic [CW-1:0] n_count;

    assign o_flags.empty = (r_count == '0);
    assign o_flags.full  = (r_count == CW'(SLOTS));
    assign o_head_slot   = r_rd;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_req.pop) begin
            n_head  = (r_head == SW'(SLOTS - 1)) ? '0 : r_head + 1'b1;
            n_count = r_count - 1'b1;
        end
        if (i_req.push) begin
            n_tail  = (r_tail == SW'(SLOTS - 1)) ? '0 : r_tail + 1'b1;
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= CW'(SLOTS);
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.clear) begin
            r_mem[i_clr_idx] <= i_clr_idx;
        end else if (i_req.push) begin
            r_mem[r_tail] <= i_push_slot;
        end
        if (i_req.pop) begin
            r_rd <= r_mem[r_head];
        end
    end

endmodule

FILE: rtl/core/gsa_gen_table.sv
module gsa_gen_table #(
    parameter int SLOTS = 256,
    parameter int GW = 16,
    localparam int SW = $clog2(SLOTS)
) (
    input  logic          i_clk,
    input  logic          i_clr,
    input  logic [SW-1:0] i_clr_idx,
    input  logic          i_rd_en,
    input  logic [SW-1:0] i_rd_addr,
    input  logic          i_wr_en,
    input  logic [SW-1:0] i_wr_addr,
    input  logic [GW-1:0] i_wr_data,
    output logic [GW-1:0] o_rd_data
);

    logic [GW-1:0] r_mem [SLOTS];
    logic [GW-1:0] r_rd;

    assign o_rd_data = r_rd;

    always_ff @(posedge i_clk) begin
        if (i_clr) begin
            r_mem[i_clr_idx] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        // same-edge write to the read address is bypassed
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd <= i_wr_data;
            end else begin
                r_rd <= r_mem[i_rd_addr];
            end
        end
    end

endmodule
